@@ rtl/ckern_pkg.sv @@
package ckern_pkg;

  localparam int CoordW = 16;
  localparam int CfgW   = 32;
  localparam int IdxW   = 3;
  localparam int EnW    = 4;
  localparam int DistW  = 42;
  localparam int DotW   = 38;
  localparam int OutW   = 48;
  localparam int TotW   = OutW + 1;
  localparam int ProdW  = 64;
  localparam int WideW  = DistW + CfgW;
  localparam int HalfW  = DistW / 2;
  localparam int FracW  = 31;
  localparam int SumW   = 34;
  localparam int TermW  = 4;
  localparam int KW     = 5;

  localparam logic [IdxW-1:0] REG_ENABLE = 3'd0;
  localparam logic [IdxW-1:0] REG_RBF    = 3'd1;
  localparam logic [IdxW-1:0] REG_WIDTH  = 3'd2;
  localparam logic [IdxW-1:0] REG_LIN    = 3'd3;
  localparam logic [IdxW-1:0] REG_BIAS   = 3'd4;
  localparam logic [IdxW-1:0] REG_WHITE  = 3'd5;

  localparam logic [EnW-1:0]  ENABLE_RST = 4'hf;
  localparam logic [CfgW-1:0] RBF_RST    = 32'd65536;
  localparam logic [CfgW-1:0] WIDTH_RST  = 32'd65536;
  localparam logic [CfgW-1:0] LIN_RST    = 32'd65536;
  localparam logic [CfgW-1:0] BIAS_RST   = 32'd8869;
  localparam logic [CfgW-1:0] WHITE_RST  = 32'd8869;

  // exp(-1) in q.30, as the truncated 13-term series gives it
  localparam logic [FracW-1:0] ONE_Q30  = 31'h4000_0000;
  localparam logic [FracW-1:0] EXP_ONE  = 31'd395007543;
  localparam logic [KW-1:0]    EXP_KMAX = 5'd22;
  localparam logic [TermW-1:0] EXP_TERMS = 4'd13;

  typedef enum logic [4:0] {
    DP_NOP, DP_X_LO, DP_X_HI, DP_X_FIN, DP_T_MUL, DP_T_REC, DP_T_DIV, DP_T_ACC,
    DP_S_DONE, DP_K_MUL, DP_K_SHIFT, DP_R_MUL, DP_R_ADD, DP_L_LO, DP_L_HI,
    DP_L_ADD, DP_FIN, DP_LOAD
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic             acc_en;
    logic [TermW-1:0] term_n;
  } dp_cmd_t;

  typedef struct packed {
    logic          exp_zero;
    logic [KW-1:0] exp_k;
    logic          out_full;
  } dp_sts_t;

  typedef struct packed {
    logic [EnW-1:0]  enable;
    logic [CfgW-1:0] rbf_var;
    logic [CfgW-1:0] inv_width;
    logic [CfgW-1:0] lin_var;
    logic [CfgW-1:0] bias_var;
    logic [CfgW-1:0] white_var;
  } cfg_t;

  // floor(2^32 / n), the n = 1 entry capped to 32 bits
  function automatic logic [CfgW-1:0] recip(input logic [TermW-1:0] n);
    logic [CfgW-1:0] r;
    case (n)
      4'd1:    r = 32'd4294967295;
      4'd2:    r = 32'd2147483648;
      4'd3:    r = 32'd1431655765;
      4'd4:    r = 32'd1073741824;
      4'd5:    r = 32'd858993459;
      4'd6:    r = 32'd715827882;
      4'd7:    r = 32'd613566756;
      4'd8:    r = 32'd536870912;
      4'd9:    r = 32'd477218588;
      4'd10:   r = 32'd429496729;
      4'd11:   r = 32'd390451572;
      4'd12:   r = 32'd357913941;
      4'd13:   r = 32'd330382099;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/ckern_regs.sv @@
module ckern_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ckern_pkg::IdxW-1:0]    cfg_index,
  input  logic [ckern_pkg::CfgW-1:0]    cfg_data,
  output ckern_pkg::cfg_t               cfg
);
  import ckern_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable    <= ENABLE_RST;
      cfg.rbf_var   <= RBF_RST;
      cfg.inv_width <= WIDTH_RST;
      cfg.lin_var   <= LIN_RST;
      cfg.bias_var  <= BIAS_RST;
      cfg.white_var <= WHITE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ENABLE: cfg.enable    <= cfg_data[EnW-1:0];
        REG_RBF:    cfg.rbf_var   <= cfg_data;
        REG_WIDTH:  cfg.inv_width <= cfg_data;
        REG_LIN:    cfg.lin_var   <= cfg_data;
        REG_BIAS:   cfg.bias_var  <= cfg_data;
        REG_WHITE:  cfg.white_var <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/ckern_dp.sv @@
module ckern_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  ckern_pkg::dp_cmd_t                 cmd,
  input  ckern_pkg::cfg_t                    cfg,
  input  logic signed [ckern_pkg::CoordW-1:0] coord_a,
  input  logic signed [ckern_pkg::CoordW-1:0] coord_b,
  input  logic                               same_point,
  input  logic                               result_ready,
  output ckern_pkg::dp_sts_t                 sts,
  output logic                               result_valid,
  output logic signed [ckern_pkg::OutW-1:0]  kernel_value,
  output logic                               saturated
);
  import ckern_pkg::*;

  logic [DistW-1:0]        dist_sq_acc;
  logic signed [DotW-1:0]  dot_acc;
  logic                    same_q;
  logic [ProdW-1:0]        prod;
  logic [WideW-1:0]        wacc;
  logic [FracW-1:0]        g;
  logic [FracW-1:0]        term;
  logic [FracW-1:0]        q;
  logic [FracW-1:0]        e;
  logic signed [SumW-1:0]  ssum;
  logic signed [TotW-1:0]  total;
  logic                    exp_zero;
  logic [KW-1:0]           exp_k;

  logic signed [CoordW:0]     diff;
  logic signed [2*CoordW+1:0] dsq;
  logic [DistW:0]             dist_sum;
  logic [DistW-1:0]           dist_next;
  logic signed [2*CoordW-1:0] ab;
  logic signed [DotW:0]       dot_sum;
  logic signed [DotW-1:0]     dot_next;
  logic [DotW-1:0]            dot_mag;
  logic [DistW-1:0]           mag_w;
  logic [CfgW-1:0]            mul_a;
  logic [CfgW-1:0]            mul_b;
  logic [ProdW-1:0]           prod_next;
  logic [WideW-1:0]           wide_sum;
  logic [FracW-1:0]           est;
  logic [FracW+TermW-1:0]     est_n;
  logic [FracW+TermW-1:0]     rem;
  logic [CfgW-1:0]            bias_add;
  logic [CfgW-1:0]            white_add;
  logic                       over;

  // accumulate one coordinate pair
  assign diff = $signed({coord_a[CoordW-1], coord_a}) - $signed({coord_b[CoordW-1], coord_b});
  assign dsq  = diff * diff;
  assign dist_sum = {1'b0, dist_sq_acc} + (DistW+1)'(dsq[2*CoordW:0]);
  assign dist_next = dist_sum[DistW] ? {DistW{1'b1}} : dist_sum[DistW-1:0];
  assign ab = coord_a * coord_b;
  assign dot_sum = (DotW+1)'(dot_acc) + (DotW+1)'(ab);
  always_comb begin
    if (dot_sum[DotW] != dot_sum[DotW-1]) begin
      dot_next = dot_sum[DotW] ? {1'b1, {(DotW-1){1'b0}}} : {1'b0, {(DotW-1){1'b1}}};
    end else begin
      dot_next = dot_sum[DotW-1:0];
    end
  end

  assign dot_mag = dot_acc[DotW-1] ? (~dot_acc + 1'b1) : dot_acc;
  assign mag_w   = DistW'(dot_mag);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      DP_X_LO: begin
        mul_a = CfgW'(dist_sq_acc[HalfW-1:0]);
        mul_b = cfg.inv_width;
      end
      DP_X_HI: begin
        mul_a = CfgW'(dist_sq_acc[DistW-1:HalfW]);
        mul_b = cfg.inv_width;
      end
      DP_T_MUL: begin
        mul_a = CfgW'(term);
        mul_b = CfgW'(g);
      end
      DP_T_REC: begin
        mul_a = CfgW'(prod[60:30]);
        mul_b = recip(cmd.term_n);
      end
      DP_K_MUL: begin
        mul_a = CfgW'(e);
        mul_b = CfgW'(EXP_ONE);
      end
      DP_R_MUL: begin
        mul_a = cfg.rbf_var;
        mul_b = CfgW'(e);
      end
      DP_L_LO: begin
        mul_a = CfgW'(mag_w[HalfW-1:0]);
        mul_b = cfg.lin_var;
      end
      DP_L_HI: begin
        mul_a = CfgW'(mag_w[DistW-1:HalfW]);
        mul_b = cfg.lin_var;
      end
      default: ;
    endcase
  end

  assign prod_next = mul_a * mul_b;
  assign wide_sum  = wacc + {prod[DistW-HalfW+CfgW-1:0], {HalfW{1'b0}}};

  // divide by term index via reciprocal, one correction step
  assign est   = prod[62:32];
  assign est_n = est * cmd.term_n;
  assign rem   = (FracW+TermW)'(q) - est_n;

  assign bias_add  = cfg.enable[2] ? cfg.bias_var : '0;
  assign white_add = (cfg.enable[3] && same_q) ? cfg.white_var : '0;
  assign over      = total[TotW-1] != total[TotW-2];

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DP_X_LO, DP_T_MUL, DP_K_MUL, DP_R_MUL, DP_L_LO: prod <= prod_next;
      DP_X_HI, DP_L_HI: begin
        wacc <= WideW'(prod[DistW-HalfW+CfgW-1:0]);
        prod <= prod_next;
      end
      DP_X_FIN: begin
        exp_zero <= (|wide_sum[73:46]) || (wide_sum[45:41] >= EXP_KMAX);
        exp_k    <= wide_sum[45:41];
        g        <= {1'b0, wide_sum[40:25], 14'b0};
        term     <= ONE_Q30;
        ssum     <= $signed(SumW'(ONE_Q30));
      end
      DP_T_REC: begin
        q    <= prod[60:30];
        prod <= prod_next;
      end
      DP_T_DIV: term <= (rem >= (FracW+TermW)'(cmd.term_n)) ? est + 1'b1 : est;
      DP_T_ACC: begin
        if (cmd.term_n[0]) begin
          ssum <= ssum - $signed(SumW'(term));
        end else begin
          ssum <= ssum + $signed(SumW'(term));
        end
      end
      DP_S_DONE: begin
        if (ssum[SumW-1]) begin
          e <= '0;
        end else if (ssum > $signed(SumW'(ONE_Q30))) begin
          e <= ONE_Q30;
        end else begin
          e <= ssum[FracW-1:0];
        end
      end
      DP_K_SHIFT: e <= prod[60:30];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_sq_acc  <= '0;
      dot_acc      <= '0;
      total        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.acc_en) begin
        dist_sq_acc <= dist_next;
        dot_acc     <= dot_next;
        same_q      <= same_point;
      end
      unique case (cmd.op)
        DP_R_ADD: total <= total + $signed(TotW'(prod[62:30]));
        DP_L_ADD: begin
          if (dot_acc[DotW-1]) begin
            total <= total - $signed(TotW'(wide_sum[69:24]));
          end else begin
            total <= total + $signed(TotW'(wide_sum[69:24]));
          end
        end
        DP_FIN: total <= total + $signed(TotW'(bias_add)) + $signed(TotW'(white_add));
        DP_LOAD: begin
          if (over) begin
            kernel_value <= total[TotW-1] ? {1'b1, {(OutW-1){1'b0}}}
                                          : {1'b0, {(OutW-1){1'b1}}};
          end else begin
            kernel_value <= total[OutW-1:0];
          end
          saturated   <= over;
          total       <= '0;
          dist_sq_acc <= '0;
          dot_acc     <= '0;
        end
        default: ;
      endcase
      if (cmd.op == DP_LOAD) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  assign sts.exp_zero = exp_zero;
  assign sts.exp_k    = exp_k;
  assign sts.out_full = result_valid && !result_ready;

endmodule

@@ rtl/ckern_ctrl.sv @@
module ckern_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  input  logic                        last_coord,
  input  logic [ckern_pkg::EnW-1:0]   enable,
  input  ckern_pkg::dp_sts_t          sts,
  output logic                        item_ready,
  output ckern_pkg::dp_cmd_t          cmd
);
  import ckern_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_X_LO, S_X_HI, S_X_FIN, S_X_CHK, S_T_MUL, S_T_REC, S_T_DIV, S_T_ACC,
    S_S_DONE, S_K_MUL, S_K_SHIFT, S_R_MUL, S_R_ADD, S_L_LO, S_L_HI, S_L_ADD,
    S_FIN, S_DONE
  } state_t;

  state_t           state;
  state_t           after_rbf;
  logic [TermW-1:0] n;
  logic [KW-1:0]    kc;

  assign item_ready = (state == S_IDLE);
  assign after_rbf  = enable[1] ? S_L_LO : S_FIN;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      n     <= 4'd1;
      kc    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item_valid && last_coord) begin
            state <= enable[0] ? S_X_LO : after_rbf;
          end
        end
        S_X_LO:  state <= S_X_HI;
        S_X_HI:  state <= S_X_FIN;
        S_X_FIN: state <= S_X_CHK;
        S_X_CHK: begin
          n     <= 4'd1;
          state <= sts.exp_zero ? after_rbf : S_T_MUL;
        end
        S_T_MUL: state <= S_T_REC;
        S_T_REC: state <= S_T_DIV;
        S_T_DIV: state <= S_T_ACC;
        S_T_ACC: begin
          if (n == EXP_TERMS) begin
            state <= S_S_DONE;
          end else begin
            n     <= n + 1'b1;
            state <= S_T_MUL;
          end
        end
        S_S_DONE: begin
          kc    <= sts.exp_k;
          state <= (sts.exp_k == '0) ? S_R_MUL : S_K_MUL;
        end
        S_K_MUL: state <= S_K_SHIFT;
        S_K_SHIFT: begin
          kc    <= kc - 1'b1;
          state <= (kc == KW'(1)) ? S_R_MUL : S_K_MUL;
        end
        S_R_MUL: state <= S_R_ADD;
        S_R_ADD: state <= after_rbf;
        S_L_LO:  state <= S_L_HI;
        S_L_HI:  state <= S_L_ADD;
        S_L_ADD: state <= S_FIN;
        S_FIN:   state <= S_DONE;
        S_DONE: begin
          if (!sts.out_full) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd.acc_en = item_valid && item_ready;
    cmd.term_n = n;
    unique case (state)
      S_X_LO:    cmd.op = DP_X_LO;
      S_X_HI:    cmd.op = DP_X_HI;
      S_X_FIN:   cmd.op = DP_X_FIN;
      S_T_MUL:   cmd.op = DP_T_MUL;
      S_T_REC:   cmd.op = DP_T_REC;
      S_T_DIV:   cmd.op = DP_T_DIV;
      S_T_ACC:   cmd.op = DP_T_ACC;
      S_S_DONE:  cmd.op = DP_S_DONE;
      S_K_MUL:   cmd.op = DP_K_MUL;
      S_K_SHIFT: cmd.op = DP_K_SHIFT;
      S_R_MUL:   cmd.op = DP_R_MUL;
      S_R_ADD:   cmd.op = DP_R_ADD;
      S_L_LO:    cmd.op = DP_L_LO;
      S_L_HI:    cmd.op = DP_L_HI;
      S_L_ADD:   cmd.op = DP_L_ADD;
      S_FIN:     cmd.op = DP_FIN;
      S_DONE:    cmd.op = sts.out_full ? DP_NOP : DP_LOAD;
      default:   cmd.op = DP_NOP;
    endcase
  end

  a_series_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_T_ACC && n == EXP_TERMS) |=> state == S_S_DONE)
    else $error("series did not finish after last term");

  a_k_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_K_SHIFT) |-> kc != '0)
    else $error("exponent step with zero count");

  a_last_starts: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && last_coord) |=> state != S_IDLE)
    else $error("final coordinate did not start evaluation");

endmodule

@@ rtl/compound_kernel_element.sv @@
// Covariance entry of an rbf + linear + bias + white kernel. Coordinate pairs
// are taken one per cycle while the block accumulates squared distance and dot
// product; the request marked last_coord starts evaluation and item_ready stays
// low until the result sits in the output register. Evaluation runs on one
// shared 32x32 multiplier. The exponential of the rbf term is zero when k, the
// integer part of d2*inv_width/2^41, reaches 22, and the series is then
// skipped; else a truncated series is followed by k multiplications by
// exp(-1). A result still waiting in the output register holds the block in
// its last cycle of evaluation. A result waiting in the output register does
// not stop accumulation of the next pair.
module compound_kernel_element (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  logic signed [ckern_pkg::CoordW-1:0] coord_a,
  input  logic signed [ckern_pkg::CoordW-1:0] coord_b,
  input  logic                                last_coord,
  input  logic                                same_point,
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic signed [ckern_pkg::OutW-1:0]   kernel_value,
  output logic                                saturated,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ckern_pkg::IdxW-1:0]          cfg_index,
  input  logic [ckern_pkg::CfgW-1:0]          cfg_data
);
  import ckern_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  ckern_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ckern_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .last_coord (last_coord),
    .enable     (cfg.enable),
    .sts        (sts),
    .item_ready (item_ready),
    .cmd        (cmd)
  );

  ckern_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg          (cfg),
    .coord_a      (coord_a),
    .coord_b      (coord_b),
    .same_point   (same_point),
    .result_ready (result_ready),
    .sts          (sts),
    .result_valid (result_valid),
    .kernel_value (kernel_value),
    .saturated    (saturated)
  );

endmodule

@@ tb/tb_compound_kernel_element.sv @@
`timescale 1ns / 100ps

module tb_compound_kernel_element;
  import ckern_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 150;
  localparam int HOLD_CYCLES = 400;
  localparam logic [IdxW-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [IdxW-1:0] REG_SPARE_HI = 3'd7;

  typedef struct {
    logic signed [OutW-1:0] kernel_value;
    logic                   saturated;
  } kernel_result_t;

  class kernel_scoreboard;
    logic [EnW-1:0]         enable;
    logic [CfgW-1:0]        rbf_var, inv_width, lin_var, bias_var, white_var;
    longint                 dist_sq, dot_sum;
    kernel_result_t         pending[$];
    int                     errors;
    int                     results_seen;

    function new();
      enable = ENABLE_RST;
      rbf_var = RBF_RST;
      inv_width = WIDTH_RST;
      lin_var = LIN_RST;
      bias_var = BIAS_RST;
      white_var = WHITE_RST;
      dist_sq = 0;
      dot_sum = 0;
      errors = 0;
      results_seen = 0;
    endfunction

    function void write_reg(logic [IdxW-1:0] idx, logic [CfgW-1:0] data);
      case (idx)
        REG_ENABLE: enable = data[EnW-1:0];
        REG_RBF:    rbf_var = data;
        REG_WIDTH:  inv_width = data;
        REG_LIN:    lin_var = data;
        REG_BIAS:   bias_var = data;
        REG_WHITE:  white_var = data;
        default: ;
      endcase
    endfunction

    function longint unsigned scaled(longint unsigned a, logic [CfgW-1:0] b, int sh);
      logic [127:0] p;
      p = 128'(a) * 128'(b);
      return 64'(p >> sh);
    endfunction

    function longint unsigned exp_series(longint unsigned g);
      longint unsigned term;
      longint          sum;
      term = longint'(1) << 30;
      sum = longint'(1) << 30;
      for (int n = 1; n <= 13; n++) begin
        term = ((term * g) >> 30) / n;
        if (n % 2 == 1) sum -= longint'(term);
        else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > (longint'(1) << 30)) sum = longint'(1) << 30;
      return sum;
    endfunction

    function longint unsigned exp_neg(longint unsigned x);
      longint unsigned k, e, e1;
      k = x >> 16;
      if (k >= 22) return 0;
      e = exp_series((x & 64'hFFFF) << 14);
      e1 = exp_series(longint'(1) << 30);
      for (int i = 0; i < k; i++) e = (e * e1) >> 30;
      return e;
    endfunction

    function void note_coord(logic signed [CoordW-1:0] a, logic signed [CoordW-1:0] b,
                             logic last, logic same);
      longint          d, total, lin;
      longint unsigned mag;
      kernel_result_t  r;
      d = longint'(a) - longint'(b);
      dist_sq += d * d;
      if (dist_sq > (longint'(1) << 42) - 1) dist_sq = (longint'(1) << 42) - 1;
      dot_sum += longint'(a) * longint'(b);
      if (dot_sum > (longint'(1) << 37) - 1) dot_sum = (longint'(1) << 37) - 1;
      if (dot_sum < -(longint'(1) << 37)) dot_sum = -(longint'(1) << 37);
      if (!last) return;
      total = 0;
      if (enable[0])
        total += longint'((longint'(rbf_var) * exp_neg(scaled(dist_sq, inv_width, 25))) >> 30);
      if (enable[1]) begin
        mag = dot_sum < 0 ? -dot_sum : dot_sum;
        lin = scaled(mag, lin_var, 24);
        total += dot_sum < 0 ? -lin : lin;
      end
      if (enable[2]) total += longint'(bias_var);
      if (enable[3] && same) total += longint'(white_var);
      r.saturated = 1'b0;
      if (total > (longint'(1) << 47) - 1) begin
        total = (longint'(1) << 47) - 1;
        r.saturated = 1'b1;
      end
      if (total < -(longint'(1) << 47)) begin
        total = -(longint'(1) << 47);
        r.saturated = 1'b1;
      end
      r.kernel_value = total[OutW-1:0];
      pending.insert(pending.size(), r);
      dist_sq = 0;
      dot_sum = 0;
    endfunction

    function void check_result(logic signed [OutW-1:0] kv, logic sat);
      kernel_result_t exp_r;
      results_seen++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result kernel_value=%0d saturated=%0b", $time, kv, sat);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (kv !== exp_r.kernel_value) begin
        $display("%0t: kernel_value expected %0d actual %0d", $time,
                 exp_r.kernel_value, kv);
        errors++;
      end
      if (sat !== exp_r.saturated) begin
        $display("%0t: saturated expected %0b actual %0b", $time, exp_r.saturated, sat);
        errors++;
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     item_valid;
  logic                     item_ready;
  logic signed [CoordW-1:0] coord_a;
  logic signed [CoordW-1:0] coord_b;
  logic                     last_coord;
  logic                     same_point;
  logic                     result_valid;
  logic                     result_ready;
  logic signed [OutW-1:0]   kernel_value;
  logic                     saturated;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [IdxW-1:0]          cfg_index;
  logic [CfgW-1:0]          cfg_data;

  kernel_scoreboard sb;
  int cycles;
  int items_sent;
  int burst_left;
  int hold_left;
  bit hold_req;
  bit hold_done;
  logic signed [CoordW-1:0] coord_a_tmp;

  compound_kernel_element dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready),
    .coord_a(coord_a), .coord_b(coord_b),
    .last_coord(last_coord), .same_point(same_point),
    .result_valid(result_valid), .result_ready(result_ready),
    .kernel_value(kernel_value), .saturated(saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial sb = new();

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("compound_kernel_element test failed");
      $finish;
    end
  end

  // accepted requests and results
  always @(posedge clk) begin
    if (!rst && item_valid && item_ready)
      sb.note_coord(coord_a, coord_b, last_coord, same_point);
    if (!rst && result_valid && result_ready)
      sb.check_result(kernel_value, saturated);
  end

  // receiver stall pattern with one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      result_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      result_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      case ((cycles / 300) % 4)
        0: result_ready <= 1'b1;
        1: result_ready <= ($urandom_range(0, 1) == 1);
        2: result_ready <= ($urandom_range(0, 4) != 0);
        default: result_ready <= (cycles % 3 == 0);
      endcase
    end
  end

  task automatic idle_gap(int n);
    item_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_coord(logic signed [CoordW-1:0] a, logic signed [CoordW-1:0] b,
                            logic last, logic same);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 6));
    end
    burst_left--;
    item_valid <= 1'b1;
    coord_a <= a;
    coord_b <= b;
    last_coord <= last;
    same_point <= same;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic write_cfg(logic [IdxW-1:0] idx, logic [CfgW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic wait_idle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_all(logic [CfgW-1:0] en, logic [CfgW-1:0] rv, logic [CfgW-1:0] iw,
                         logic [CfgW-1:0] lv, logic [CfgW-1:0] bv, logic [CfgW-1:0] wv);
    write_cfg(REG_ENABLE, en);
    write_cfg(REG_RBF, rv);
    write_cfg(REG_WIDTH, iw);
    write_cfg(REG_LIN, lv);
    write_cfg(REG_BIAS, bv);
    write_cfg(REG_WHITE, wv);
    write_cfg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [CoordW-1:0] pick_coord();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      1: return $signed(16'($urandom_range(0, 512))) - 16'sd256;
      2: return $signed(16'($urandom_range(0, 8192))) - 16'sd4096;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic run_pairs(int n);
    int sent, len;
    logic same;
    sent = 0;
    while (sent < n) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3: len = $urandom_range(9, 64);
        4: len = $urandom_range(65, 100);
        default: len = $urandom_range(1, 8);
      endcase
      same = $urandom_range(0, 1);
      for (int i = 0; i < len; i++) begin
        if (same && $urandom_range(0, 3) != 0) begin
          coord_a_tmp = pick_coord();
          send_coord(coord_a_tmp, coord_a_tmp, i == len - 1, same);
        end else begin
          send_coord(pick_coord(), pick_coord(), i == len - 1, same);
        end
      end
      sent += len;
    end
  endtask

  function automatic logic [CfgW-1:0] pick_width();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 255);
      default: return $urandom_range(0, 32'h0002_0000);
    endcase
  endfunction

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    coord_a = '0;
    coord_b = '0;
    last_coord = 1'b0;
    same_point = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    items_sent = 0;
    burst_left = 0;
    hold_req = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed pairs at reset settings
    send_coord(16'sh8000, 16'sh7fff, 1'b1, 1'b0);
    send_coord(16'sh7fff, 16'sh8000, 1'b1, 1'b1);
    send_coord(16'sh8000, 16'sh8000, 1'b1, 1'b1);
    send_coord(16'sh7fff, 16'sh7fff, 1'b1, 1'b0);
    send_coord(16'sh0000, 16'sh0000, 1'b1, 1'b1);
    send_coord(16'sh0000, 16'sh0000, 1'b1, 1'b0);
    send_coord(16'sh1000, 16'sh0000, 1'b0, 1'b0);
    send_coord(16'shf000, 16'sh1000, 1'b1, 1'b1);
    send_coord(16'sh1000, 16'sh1000, 1'b0, 1'b1);
    send_coord(16'sh2000, 16'sh2000, 1'b1, 1'b1);
    send_coord(16'sh0001, 16'shffff, 1'b0, 1'b0);
    send_coord(16'sh5555, 16'shaaaa, 1'b0, 1'b1);
    send_coord(16'shaaaa, 16'sh5555, 1'b1, 1'b0);
    send_coord(16'sh0800, 16'shf800, 1'b1, 1'b0);
    wait_idle();

    set_all(32'd0, $urandom, $urandom, $urandom, $urandom, $urandom);
    run_pairs(50);
    wait_idle();
    set_all(32'd15, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
            32'hffff_ffff);
    run_pairs(70);
    wait_idle();
    set_all(32'd15, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    run_pairs(50);
    wait_idle();

    // long hold-off while requests keep coming
    set_all(32'd15, $urandom, 32'd2, $urandom, $urandom, $urandom);
    hold_req = 1'b1;
    run_pairs(60);
    wait_idle();

    // dot product pushed to both limits
    set_all(32'd15, 32'hffff_ffff, 32'd1, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    for (int i = 0; i < 130; i++) send_coord(16'sh8000, 16'sh8000, i == 129, 1'b1);
    for (int i = 0; i < 140; i++) send_coord(16'sh7fff, 16'sh8000, i == 139, 1'b0);
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      set_all($urandom_range(0, 15), $urandom, pick_width(), $urandom, $urandom, $urandom);
      run_pairs(40);
      wait_idle();
    end

    $display("run covered %0d coordinate requests and %0d kernel results", items_sent,
             sb.results_seen);
    $display("enable masks, extreme and random variances, accumulator saturation, long stall");
    if (sb.errors == 0) $display("compound_kernel_element test passed");
    else $display("compound_kernel_element test failed");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/ckern_pkg.sv
rtl/ckern_regs.sv
rtl/ckern_dp.sv
rtl/ckern_ctrl.sv
rtl/compound_kernel_element.sv
tb/tb_compound_kernel_element.sv
